/* rtl/core/ntcat_pkg.sv */
// Shared types and constants of the NTC thermistor temperature block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package ntcat_pkg;

    localparam int SERIES_TERMS_DEF = 15;
    localparam int ADC_BITS_DEF     = 12;

    localparam int SAMPLE_W = 12;
    localparam int BETA_W   = 13;
    localparam int DEG_W    = 8;
    localparam int CODE_W   = 12;
    localparam int CFG_W    = 13;
    localparam int IDX_W    = 2;

    localparam int SIXT_W = 15;
    localparam int RDEG_W = 11;

    // Fixed-point widths: square and series sum in Q30, quotient bits.
    localparam int XW     = 31;
    localparam int YW     = 32;
    localparam int LW     = 26;
    localparam int DEN_W  = 43;
    localparam int DMAG_W = 42;
    localparam int REM_W  = 70;
    localparam int QUO_W  = 28;
    localparam int C16_W  = 29;

    localparam logic [14:0] T25_X100 = 15'd29815;
    localparam logic [6:0]  BETA_SCALE = 7'd100;

    localparam logic signed [C16_W-1:0] KELVIN_OFS_Q16 = 29'sd17901158;
    localparam logic signed [C16_W-1:0] C_MIN_Q16      = -29'sd7208960;
    localparam logic signed [C16_W-1:0] C_MAX_Q16      = 29'sd53084160;

    localparam logic signed [SIXT_W-1:0] SIXT_MIN = -15'sd1760;
    localparam logic signed [RDEG_W-1:0] RDEG_MIN = -11'sd110;

    localparam logic [BETA_W-1:0] BETA_RST = 13'd3435;
    localparam logic [DEG_W-1:0]  LOW_RST  = 8'd75;
    localparam logic [DEG_W-1:0]  HIGH_RST = 8'd90;
    localparam logic [CODE_W-1:0] MAXC_RST = 12'd4095;

    typedef enum logic [IDX_W-1:0] {
        REG_BETA      = 2'd0,
        REG_PROT_LOW  = 2'd1,
        REG_PROT_HIGH = 2'd2,
        REG_PROT_MAX  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic zero;
        logic neg;
    } t_tag;

    typedef struct packed {
        logic [DEG_W-1:0]  low;
        logic [DEG_W-1:0]  high;
        logic [CODE_W-1:0] max_code;
    } t_prot_cfg;

endpackage
`default_nettype wire

/* rtl/core/ntcat_series_cell.sv */
// One Horner step of the atanh series: y <= 1/nk + xx*y, all in Q30.
// Depends on ntcat_pkg.
`default_nettype none
module ntcat_series_cell #(
    parameter int ADC_BITS = 12,
    parameter int NK       = 1
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  wire                        i_valid,
    input  wire ntcat_pkg::t_tag       i_tag,
    input  wire [ADC_BITS-1:0]         i_dmag,
    input  wire [ntcat_pkg::XW-1:0]    i_xx,
    input  wire [ntcat_pkg::YW-1:0]    i_y,
    output logic                       o_valid,
    output ntcat_pkg::t_tag            o_tag,
    output logic [ADC_BITS-1:0]        o_dmag,
    output logic [ntcat_pkg::XW-1:0]   o_xx,
    output logic [ntcat_pkg::YW-1:0]   o_y
);
    import ntcat_pkg::*;

    localparam int PW = XW + YW;
    localparam logic [YW-1:0] RECIP =
        YW'(((64'd1 << 30) + 64'(NK / 2)) / 64'(NK));
    localparam logic [PW-1:0] ROUND = PW'(64'd1 << 29);

    logic [PW-1:0] prod_c;
    logic [PW-1:0] rnd_c;
    logic [YW-1:0] n_y;

    assign prod_c = PW'(i_xx) * PW'(i_y);
    assign rnd_c  = prod_c + ROUND;
    assign n_y    = RECIP + rnd_c[30 +: YW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_tag  <= i_tag;
            o_dmag <= i_dmag;
            o_xx   <= i_xx;
            o_y    <= n_y;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/ntcat_div_cell.sv */
// One restoring-division step: decides quotient bit BIT of rem / den.
// Depends on ntcat_pkg.
`default_nettype none
module ntcat_div_cell #(
    parameter int BIT = 0
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire ntcat_pkg::t_tag         i_tag,
    input  wire                          i_sat,
    input  wire [ntcat_pkg::REM_W-1:0]   i_rem,
    input  wire [ntcat_pkg::DMAG_W-1:0]  i_den,
    input  wire [ntcat_pkg::QUO_W-1:0]   i_quo,
    output logic                         o_valid,
    output ntcat_pkg::t_tag              o_tag,
    output logic                         o_sat,
    output logic [ntcat_pkg::REM_W-1:0]  o_rem,
    output logic [ntcat_pkg::DMAG_W-1:0] o_den,
    output logic [ntcat_pkg::QUO_W-1:0]  o_quo
);
    import ntcat_pkg::*;

    logic [REM_W-1:0] cmp_c;
    logic             take_c;
    logic [QUO_W-1:0] n_quo;

    assign cmp_c  = REM_W'(i_den) << BIT;
    assign take_c = (i_rem >= cmp_c);

    always_comb begin
        n_quo      = i_quo;
        n_quo[BIT] = take_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_tag <= i_tag;
            o_sat <= i_sat;
            o_rem <= take_c ? (i_rem - cmp_c) : i_rem;
            o_den <= i_den;
            o_quo <= n_quo;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/ntcat_finish.sv */
// Kelvin-to-Celsius conversion, clamping, display rounding and protection level.
// Three register stages, the last being the output register. Depends on ntcat_pkg.
`default_nettype none
module ntcat_finish (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_en,
    input  wire                               i_valid,
    input  wire ntcat_pkg::t_tag              i_tag,
    input  wire                               i_sat,
    input  wire [ntcat_pkg::QUO_W-1:0]        i_quo,
    input  wire ntcat_pkg::t_prot_cfg         i_cfg,
    output logic                              o_valid,
    output logic signed [ntcat_pkg::SIXT_W-1:0] o_sixt,
    output logic signed [ntcat_pkg::RDEG_W-1:0] o_rdeg,
    output logic [ntcat_pkg::CODE_W-1:0]      o_level,
    output logic                              o_zero
);
    import ntcat_pkg::*;

    // Stage G: Celsius in Q16, clamped.
    logic signed [C16_W-1:0] t_c;
    logic signed [C16_W-1:0] n_c16;
    logic signed [C16_W-1:0] r_c16;
    logic                    r_g_valid;
    logic                    r_g_zero;

    assign t_c = $signed({2'b00, i_quo[QUO_W-2:0]}) - KELVIN_OFS_Q16;

    always_comb begin
        if (i_sat || i_quo[QUO_W-1]) begin
            n_c16 = C_MAX_Q16;
        end else if (t_c < C_MIN_Q16) begin
            n_c16 = C_MIN_Q16;
        end else if (t_c > C_MAX_Q16) begin
            n_c16 = C_MAX_Q16;
        end else begin
            n_c16 = t_c;
        end
    end

    // Stage H: sixteenths, tenths-rounded whole degrees before the divide by ten,
    // and the protection level.
    logic signed [32:0]      v_c;
    logic [32:0]             vabs_c;
    logic signed [C16_W-1:0] six_sum_c;
    logic signed [C16_W-1:0] low_c;
    logic signed [C16_W-1:0] high_c;
    logic                    ge_low_c;
    logic                    ge_high_c;
    logic [CODE_W-1:0]       n_level;
    logic                    r_h_valid;
    logic                    r_h_zero;
    logic [SIXT_W-1:0]       r_h_six;
    logic [13:0]             r_h_qmag;
    logic                    r_h_qneg;
    logic [CODE_W-1:0]       r_h_level;

    assign v_c       = (33'(r_c16) <<< 3) + (33'(r_c16) <<< 1) + 33'sd327680;
    assign vabs_c    = v_c[32] ? 33'(-v_c) : 33'(v_c);
    assign six_sum_c = r_c16 + 29'sd2048;
    assign low_c     = $signed({5'b0, i_cfg.low, 16'b0});
    assign high_c    = $signed({5'b0, i_cfg.high, 16'b0});
    assign ge_low_c  = (r_c16 >= low_c);
    assign ge_high_c = (r_c16 >= high_c);

    always_comb begin
        if (ge_low_c && !ge_high_c) begin
            n_level = r_c16[16 +: CODE_W];
        end else if (ge_high_c) begin
            n_level = i_cfg.max_code;
        end else begin
            n_level = '0;
        end
    end

    // Output stage: divide by ten through a reciprocal multiply, exact for |q| < 2^14.
    logic [29:0]       deg_prod_c;
    logic [RDEG_W-1:0] deg_mag_c;

    assign deg_prod_c = 30'(r_h_qmag) * 30'(17'd52429);
    assign deg_mag_c  = deg_prod_c[19 +: RDEG_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
            r_h_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else if (i_en) begin
            r_g_valid <= i_valid;
            r_h_valid <= r_g_valid;
            o_valid   <= r_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c16     <= n_c16;
            r_g_zero  <= i_tag.zero;
            r_h_zero  <= r_g_zero;
            r_h_six   <= six_sum_c[12 +: SIXT_W];
            r_h_qmag  <= vabs_c[16 +: 14];
            r_h_qneg  <= v_c[32];
            r_h_level <= n_level;
            if (r_h_zero) begin
                o_sixt  <= SIXT_MIN;
                o_rdeg  <= RDEG_MIN;
                o_level <= '0;
            end else begin
                o_sixt  <= $signed(r_h_six);
                o_rdeg  <= r_h_qneg ? $signed(-deg_mag_c) : $signed(deg_mag_c);
                o_level <= r_h_level;
            end
            o_zero <= r_h_zero;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/ntc_adc_to_temperature.sv */
// NTC thermistor ADC sample to temperature, Beta equation, fully pipelined.
// Depends on ntcat_pkg, ntcat_series_cell, ntcat_div_cell and ntcat_finish.
//
// Usage: a sample is transferred on the input channel when i_in_valid and
// o_in_ready are both high; its result is transferred on the output channel
// when o_out_valid and i_out_ready are both high. One result per sample, in order.
// The block is a single pipeline: one front stage, SERIES_TERMS atanh cells
// in Horner form, four stages for the logarithm and the Beta denominator,
// 28 restoring divider cells and three finishing stages. Throughput is
// one sample per cycle while the receiver takes results; the whole chain
// moves together. When the receiver stalls with a result waiting, the
// chain holds and o_in_ready drops until that result is transferred.
// Reset clears all valid bits and loads the registers with their defaults.
// Configuration writes through i_cfg_we / i_cfg_index / i_cfg_data take
// effect at the next edge and must only be made while the pipeline is empty.
// A zero sample flags o_adc_zero_error and gives the coldest readings.
`default_nettype none
module ntc_adc_to_temperature #(
    parameter int SERIES_TERMS = ntcat_pkg::SERIES_TERMS_DEF,
    parameter int ADC_BITS     = ntcat_pkg::ADC_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire [ntcat_pkg::SAMPLE_W-1:0]       i_adc_sample,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic signed [ntcat_pkg::SIXT_W-1:0] o_celsius_sixteenths,
    output logic signed [ntcat_pkg::RDEG_W-1:0] o_rounded_degrees,
    output logic [ntcat_pkg::CODE_W-1:0]        o_protection_level,
    output logic                                o_adc_zero_error,
    input  wire                                 i_cfg_we,
    input  wire [ntcat_pkg::IDX_W-1:0]          i_cfg_index,
    input  wire [ntcat_pkg::CFG_W-1:0]          i_cfg_data
);
    import ntcat_pkg::*;

    localparam int N   = SERIES_TERMS;
    localparam int XSH = 32 - 2 * ADC_BITS;
    localparam int LSH = 32 - ADC_BITS;
    localparam logic [ADC_BITS-1:0] HALF = {1'b1, {(ADC_BITS-1){1'b0}}};
    localparam logic [YW-1:0] Y_INIT =
        YW'(((64'd1 << 30) + 64'((2 * N + 1) / 2)) / 64'(2 * N + 1));
    localparam int DW = ADC_BITS + YW;

    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Configuration registers.
    logic [BETA_W-1:0] r_beta;
    t_prot_cfg         r_prot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta        <= BETA_RST;
            r_prot.low    <= LOW_RST;
            r_prot.high   <= HIGH_RST;
            r_prot.max_code <= MAXC_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_BETA:      r_beta          <= i_cfg_data[BETA_W-1:0];
                REG_PROT_LOW:  r_prot.low      <= i_cfg_data[DEG_W-1:0];
                REG_PROT_HIGH: r_prot.high     <= i_cfg_data[DEG_W-1:0];
                REG_PROT_MAX:  r_prot.max_code <= i_cfg_data[CODE_W-1:0];
                default:       r_beta          <= r_beta;
            endcase
        end
    end

    // Front stage: distance from mid-scale and its square in Q30.
    logic [ADC_BITS-1:0]   adc_c;
    logic [ADC_BITS-1:0]   dmag_c;
    logic [2*ADC_BITS-1:0] sq_c;

    assign adc_c  = ADC_BITS'(i_adc_sample);
    assign dmag_c = (adc_c >= HALF) ? (adc_c - HALF) : (HALF - adc_c);
    assign sq_c   = dmag_c * dmag_c;

    logic                s_valid [0:N];
    t_tag                s_tag   [0:N];
    logic [ADC_BITS-1:0] s_dmag  [0:N];
    logic [XW-1:0]       s_xx    [0:N];
    logic [YW-1:0]       s_y     [0:N];

    assign s_y[0] = Y_INIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid[0] <= 1'b0;
        end else if (en) begin
            s_valid[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            s_tag[0].zero <= (adc_c == '0);
            s_tag[0].neg  <= (adc_c < HALF);
            s_dmag[0]     <= dmag_c;
            s_xx[0]       <= XW'(64'(sq_c) << XSH);
        end
    end

    for (genvar gi = 0; gi < N; gi++) begin : g_series
        ntcat_series_cell #(
            .ADC_BITS (ADC_BITS),
            .NK       (2 * (N - gi) - 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_valid[gi]),
            .i_tag   (s_tag[gi]),
            .i_dmag  (s_dmag[gi]),
            .i_xx    (s_xx[gi]),
            .i_y     (s_y[gi]),
            .o_valid (s_valid[gi+1]),
            .o_tag   (s_tag[gi+1]),
            .o_dmag  (s_dmag[gi+1]),
            .o_xx    (s_xx[gi+1]),
            .o_y     (s_y[gi+1])
        );
    end

    // Stage L: ln magnitude = 2*mag*y, rounded to Q30 then to Q20.
    logic [DW-1:0] lp_c;
    logic [63:0]   l30_c;
    logic [63:0]   l20_c;
    logic          r_l_valid;
    t_tag          r_l_tag;
    logic [LW-1:0] r_l20;

    assign lp_c  = DW'(s_dmag[N]) * DW'(s_y[N]);
    assign l30_c = ((64'(lp_c) << LSH) + (64'd1 << 29)) >> 30;
    assign l20_c = l30_c + 64'd512;

    // Stage M: the three products of the Beta equation.
    logic          r_m_valid;
    t_tag          r_m_tag;
    logic [40:0]   r_m_lprod;
    logic [19:0]   r_m_b100;
    logic [27:0]   r_m_nb;

    // Stage D: denominator 100*B*2^20 - ln20*29815, or + for a sample below mid-scale.
    logic signed [DEN_W-1:0] den_c;
    logic                    r_d_valid;
    t_tag                    r_d_tag;
    logic signed [DEN_W-1:0] r_d_den;
    logic [27:0]             r_d_nb;

    assign den_c = r_m_tag.neg
        ? $signed({3'b000, r_m_b100, 20'b0}) + $signed({2'b00, r_m_lprod})
        : $signed({3'b000, r_m_b100, 20'b0}) - $signed({2'b00, r_m_lprod});

    // Stage E: rounded numerator and the non-positive denominator check.
    logic                    dpos_c;
    logic                    q_valid [0:QUO_W];
    t_tag                    q_tag   [0:QUO_W];
    logic                    q_sat   [0:QUO_W];
    logic [REM_W-1:0]        q_rem   [0:QUO_W];
    logic [DMAG_W-1:0]       q_den   [0:QUO_W];
    logic [QUO_W-1:0]        q_quo   [0:QUO_W];

    assign dpos_c   = !r_d_den[DEN_W-1] && (r_d_den != '0);
    assign q_quo[0] = '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_valid  <= 1'b0;
            r_m_valid  <= 1'b0;
            r_d_valid  <= 1'b0;
            q_valid[0] <= 1'b0;
        end else if (en) begin
            r_l_valid  <= s_valid[N];
            r_m_valid  <= r_l_valid;
            r_d_valid  <= r_m_valid;
            q_valid[0] <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l_tag   <= s_tag[N];
            r_l20     <= l20_c[10 +: LW];
            r_m_tag   <= r_l_tag;
            r_m_lprod <= 41'(r_l20) * 41'(T25_X100);
            r_m_b100  <= 20'(r_beta) * 20'(BETA_SCALE);
            r_m_nb    <= 28'(r_beta) * 28'(T25_X100);
            r_d_tag   <= r_m_tag;
            r_d_den   <= den_c;
            r_d_nb    <= r_m_nb;
            q_tag[0]  <= r_d_tag;
            q_sat[0]  <= !dpos_c;
            q_rem[0]  <= REM_W'({r_d_nb, 36'b0}) + REM_W'(r_d_den[DMAG_W-1:1]);
            q_den[0]  <= r_d_den[DMAG_W-1:0];
        end
    end

    // Divider chain, most significant quotient bit first. The top bit marks
    // a kelvin value beyond the upper clamp.
    for (genvar gd = 0; gd < QUO_W; gd++) begin : g_div
        ntcat_div_cell #(
            .BIT (QUO_W - 1 - gd)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (q_valid[gd]),
            .i_tag   (q_tag[gd]),
            .i_sat   (q_sat[gd]),
            .i_rem   (q_rem[gd]),
            .i_den   (q_den[gd]),
            .i_quo   (q_quo[gd]),
            .o_valid (q_valid[gd+1]),
            .o_tag   (q_tag[gd+1]),
            .o_sat   (q_sat[gd+1]),
            .o_rem   (q_rem[gd+1]),
            .o_den   (q_den[gd+1]),
            .o_quo   (q_quo[gd+1])
        );
    end

    ntcat_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid[QUO_W]),
        .i_tag   (q_tag[QUO_W]),
        .i_sat   (q_sat[QUO_W]),
        .i_quo   (q_quo[QUO_W]),
        .i_cfg   (r_prot),
        .o_valid (o_out_valid),
        .o_sixt  (o_celsius_sixteenths),
        .o_rdeg  (o_rounded_degrees),
        .o_level (o_protection_level),
        .o_zero  (o_adc_zero_error)
    );

endmodule
`default_nettype wire
